// File: rtl/core/gbn_pkg.sv
// ---------------------------------------------------------------------------
// Go-back-N endpoint package
// Shared constants, codes and the queue entry type.
// ---------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_MAX = 7;
  localparam int SLOTS = SEQ_MAX + 1;

  // Input commands.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_ARRIVE = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_SENT = 3'd0;
  localparam logic [2:0] KIND_REFUSED = 3'd1;
  localparam logic [2:0] KIND_DELIVERED = 3'd2;
  localparam logic [2:0] KIND_ACK_ONLY = 3'd3;
  localparam logic [2:0] KIND_RESENT = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_STEP = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  // One classified word passed from the front to the back.
  typedef struct packed {
    logic [1:0] command;
    logic [63:0] payload;
    logic [2:0] rx_seq;
    logic [2:0] rx_ack;
  } cmd_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_RESEND,
    ST_OUT
  } back_state_t;

endpackage

// File: rtl/core/go_back_n_link_endpoint_core.sv
// ---------------------------------------------------------------------------
// Go-back-N link endpoint core
// Sliding-window sender and in-order receiver with timed retransmission.
// ---------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | input     | tuser: command; tdata: payload, rx_seq, rx_ack
// out_    | output    | tuser: kind; tdata: seq, data, outstanding; tlast: last
// cfg_    | input     | timeout_base, timeout_step, window_limit
//
// A send or an arrival leaves the queue as its word is loaded into the output
// register; the back end then passes through its output state.
// A tick steps through the outstanding frames in turn; on expiry the deadline
// pipeline settles before a resend burst of one word per cycle while the
// output is free. Reset is synchronous; output stalls hold the back end, and
// a two-word queue lets the input run ahead of them.
// ---------------------------------------------------------------------------
module go_back_n_link_endpoint_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // command
  input  logic [71:0] in_tdata,   // payload, rx_seq, rx_ack, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // kind
  output logic [71:0] out_tdata,  // seq, data, outstanding, zero fill
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] base_r;
  logic [7:0] step_r;
  logic [2:0] limit_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'd3;
      step_r <= 8'd3;
      limit_r <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::REG_BASE: base_r <= cfg_wdata;
        gbn_pkg::REG_STEP: step_r <= cfg_wdata[7:0];
        gbn_pkg::REG_LIMIT: limit_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  gbn_pkg::cmd_entry_t in_entry, q_entry;
  logic q_valid, q_pop;
  logic [2:0] seq, outs;
  logic [63:0] data;

  assign in_entry.command = in_tuser;
  assign in_entry.payload = in_tdata[63:0];
  assign in_entry.rx_seq = in_tdata[66:64];
  assign in_entry.rx_ack = in_tdata[69:67];

  gbn_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_entry,
    .q_valid, .q_pop, .q_entry
  );

  gbn_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_entry,
    .timeout_base(base_r), .timeout_step(step_r), .window_limit(limit_r),
    .out_tvalid, .out_tready,
    .out_kind(out_tuser), .out_seq(seq), .out_data(data),
    .out_outstanding(outs), .out_last(out_tlast)
  );

  assign out_tdata = {2'b00, outs, data, seq};

endmodule

// File: rtl/core/gbn_front.sv
// ---------------------------------------------------------------------------
// Go-back-N front end
// Accepts input words, drops unused commands and queues the rest.
// ---------------------------------------------------------------------------
module gbn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  gbn_pkg::cmd_entry_t in_entry,
  output logic               q_valid,
  input  logic               q_pop,
  output gbn_pkg::cmd_entry_t q_entry
);

  // Two-entry queue.
  gbn_pkg::cmd_entry_t mem_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic push;

  assign in_tready = (count_r != 2'd2);
  assign push = in_tvalid && in_tready && (in_entry.command != gbn_pkg::CMD_IGNORED);
  assign q_valid = (count_r != 2'd0);
  assign q_entry = mem_r[rd_ptr_r];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_entry;
    end
  end

  // Pointer and fill control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: rtl/core/gbn_back.sv
// ---------------------------------------------------------------------------
// Go-back-N back end
// Executes queued commands against the window state and emits results.
// ---------------------------------------------------------------------------
module gbn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  gbn_pkg::cmd_entry_t q_entry,
  input  logic [15:0]        timeout_base,
  input  logic [7:0]         timeout_step,
  input  logic [2:0]         window_limit,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2:0]         out_kind,
  output logic [2:0]         out_seq,
  output logic [63:0]        out_data,
  output logic [2:0]         out_outstanding,
  output logic               out_last
);

  gbn_pkg::back_state_t state_r, state_nxt;
  logic [63:0] store_r [gbn_pkg::SLOTS];
  logic [15:0] timer_r [gbn_pkg::SLOTS];
  logic [2:0] next_seq_r, oldest_r, expect_r, wcount_r;
  logic [2:0] idx_r;
  logic [2:0] cnt_r;
  logic expired_r;
  logic [15:0] deadline_r;

  // Output holding register.
  logic ov_r;
  logic [2:0] ok_r, os_r, oo_r;
  logic [63:0] od_r;
  logic ol_r;

  assign out_tvalid = ov_r;
  assign out_kind = ok_r;
  assign out_seq = os_r;
  assign out_data = od_r;
  assign out_outstanding = oo_r;
  assign out_last = ol_r;

  logic out_free;
  assign out_free = !ov_r || out_tready;

  // A new word is loaded into the output register this cycle.
  logic out_load;
  assign out_load = out_free &&
                    ((state_r == gbn_pkg::ST_IDLE && q_valid &&
                      (q_entry.command inside {gbn_pkg::CMD_SEND, gbn_pkg::CMD_ARRIVE})) ||
                     (state_r == gbn_pkg::ST_RESEND && cnt_r == 3'd0));

  // Deadline: registered product, then saturated sum.
  logic [10:0] prod_r;
  logic [16:0] dsum;
  always_ff @(posedge clk) begin
    prod_r <= timeout_step * expect_r;
  end
  assign dsum = {1'b0, timeout_base} + {6'd0, prod_r};
  always_ff @(posedge clk) begin
    deadline_r <= dsum[16] ? 16'hFFFF : dsum[15:0];
  end

  // Decode for the current queued word.
  logic [2:0] lim, ack_span, cur_idx;
  logic send_ok, ack_hit, deliver;
  logic [15:0] tdec;
  always_comb begin
    lim = (window_limit > 3'(gbn_pkg::SEQ_MAX)) ? 3'(gbn_pkg::SEQ_MAX) : window_limit;
    send_ok = (wcount_r < lim);
    ack_span = q_entry.rx_ack - oldest_r;
    ack_hit = (ack_span < wcount_r);
    deliver = (q_entry.rx_seq == expect_r);
    cur_idx = oldest_r + idx_r;
    tdec = (timer_r[cur_idx] != 16'd0) ? timer_r[cur_idx] - 16'd1 : 16'd0;
  end

  // Next state and pop control.
  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    case (state_r)
      gbn_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          if (q_entry.command == gbn_pkg::CMD_TICK) begin
            if (wcount_r == 3'd0) q_pop = 1'b1;
            else state_nxt = gbn_pkg::ST_TICK;
          end else begin
            q_pop = 1'b1;
            state_nxt = gbn_pkg::ST_OUT;
          end
        end
      end
      gbn_pkg::ST_TICK: begin
        if (idx_r + 3'd1 == wcount_r) begin
          if (expired_r || tdec == 16'd0) state_nxt = gbn_pkg::ST_RESEND;
          else begin
            state_nxt = gbn_pkg::ST_IDLE;
            q_pop = 1'b1;
          end
        end
      end
      gbn_pkg::ST_RESEND: begin
        if (out_free && cnt_r == 3'd0 && idx_r + 3'd1 == wcount_r) begin
          state_nxt = gbn_pkg::ST_IDLE;
          q_pop = 1'b1;
        end
      end
      gbn_pkg::ST_OUT: state_nxt = gbn_pkg::ST_IDLE;
      default: state_nxt = gbn_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbn_pkg::ST_IDLE;
      next_seq_r <= 3'd0;
      oldest_r <= 3'd0;
      expect_r <= 3'd0;
      wcount_r <= 3'd0;
      idx_r <= 3'd0;
      cnt_r <= 3'd0;
      expired_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i < gbn_pkg::SLOTS; i++) timer_r[i] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        gbn_pkg::ST_IDLE: begin
          idx_r <= 3'd0;
          expired_r <= 1'b0;
          cnt_r <= 3'd2;
          if (q_valid && out_free && q_entry.command == gbn_pkg::CMD_SEND) begin
            ol_r <= 1'b1;
            if (send_ok) begin
              store_r[next_seq_r] <= q_entry.payload;
              next_seq_r <= next_seq_r + 3'd1;
              wcount_r <= wcount_r + 3'd1;
              ok_r <= gbn_pkg::KIND_SENT;
              os_r <= next_seq_r;
              od_r <= q_entry.payload;
              oo_r <= wcount_r + 3'd1;
            end else begin
              ok_r <= gbn_pkg::KIND_REFUSED;
              os_r <= 3'd0;
              od_r <= 64'd0;
              oo_r <= wcount_r;
            end
          end else if (q_valid && out_free && q_entry.command == gbn_pkg::CMD_ARRIVE) begin
            ol_r <= 1'b1;
            if (deliver) expect_r <= expect_r + 3'd1;
            if (ack_hit) begin
              // Timers of freed slots are left alone; a later send reloads them.
              oldest_r <= q_entry.rx_ack + 3'd1;
              wcount_r <= wcount_r - ack_span - 3'd1;
              oo_r <= wcount_r - ack_span - 3'd1;
            end else begin
              oo_r <= wcount_r;
            end
            ok_r <= deliver ? gbn_pkg::KIND_DELIVERED : gbn_pkg::KIND_ACK_ONLY;
            os_r <= deliver ? q_entry.rx_seq : 3'd0;
            od_r <= deliver ? q_entry.payload : 64'd0;
          end
        end
        gbn_pkg::ST_OUT: begin
          // Restart the timer of a freshly sent frame with the current deadline.
          if (ok_r == gbn_pkg::KIND_SENT) timer_r[os_r] <= deadline_r;
        end
        gbn_pkg::ST_TICK: begin
          timer_r[cur_idx] <= tdec;
          if (tdec == 16'd0) expired_r <= 1'b1;
          if (idx_r + 3'd1 != wcount_r) idx_r <= idx_r + 3'd1;
          else idx_r <= 3'd0;
        end
        gbn_pkg::ST_RESEND: begin
          // Let the deadline pipeline settle before the burst.
          if (cnt_r != 3'd0) cnt_r <= cnt_r - 3'd1;
          else if (out_free) begin
            timer_r[cur_idx] <= deadline_r;
            ok_r <= gbn_pkg::KIND_RESENT;
            os_r <= cur_idx;
            od_r <= store_r[cur_idx];
            oo_r <= wcount_r;
            ol_r <= (idx_r + 3'd1 == wcount_r);
            idx_r <= idx_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sim/gbn_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Go-back-N endpoint checker
// Watches the configuration port and both stream channels, predicts every
// result word from the accepted input words, and compares in order.
// ---------------------------------------------------------------------------
module gbn_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [2:0]  out_tuser,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  seq;
    logic [63:0] data;
    logic [2:0]  outstanding;
    logic        last;
  } link_word_t;

  link_word_t expected_words[$];

  // Shadow copy of the endpoint state.
  logic [15:0] base_ticks;
  logic [7:0]  step_ticks;
  logic [2:0]  win_limit;
  logic [63:0] frame_buf[gbn_pkg::SLOTS];
  logic [15:0] timer_left[gbn_pkg::SLOTS];
  logic [2:0]  tx_next;
  logic [2:0]  tx_oldest;
  logic [2:0]  rx_next;
  logic [2:0]  in_flight;

  assign pending = expected_words.size();

  function automatic logic [15:0] retry_deadline();
    int d;
    d = int'(base_ticks) + int'(step_ticks) * int'(rx_next);
    return (d > 65535) ? 16'hFFFF : d[15:0];
  endfunction

  function automatic link_word_t make_word(logic [2:0] kind, logic [2:0] seq,
                                           logic [63:0] data, logic [2:0] outs,
                                           logic last);
    link_word_t w;
    w.kind = kind;
    w.seq = seq;
    w.data = data;
    w.outstanding = outs;
    w.last = last;
    return w;
  endfunction

  // Append one predicted word at the tail of the queue.
  function automatic void add_expected(link_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Advance the shadow state by one input word and queue its results.
  task automatic predict_link(logic [1:0] user, logic [71:0] word);
    logic [1:0]  cmd;
    logic [63:0] pay;
    logic [2:0]  rseq;
    logic [2:0]  rack;
    logic [2:0]  lim;
    logic [2:0]  span;
    logic [2:0]  idx;
    logic        hit;
    logic        expired;
    logic [15:0] d;
    cmd = user;
    pay = word[63:0];
    rseq = word[66:64];
    rack = word[69:67];
    case (cmd)
      gbn_pkg::CMD_SEND: begin
        lim = win_limit;
        if (in_flight >= lim) begin
          add_expected(make_word(gbn_pkg::KIND_REFUSED, 3'd0, 64'd0, in_flight, 1'b1));
        end else begin
          frame_buf[tx_next] = pay;
          timer_left[tx_next] = retry_deadline();
          in_flight = in_flight + 3'd1;
          add_expected(make_word(gbn_pkg::KIND_SENT, tx_next, pay, in_flight, 1'b1));
          tx_next = tx_next + 3'd1;
        end
      end
      gbn_pkg::CMD_ARRIVE: begin
        hit = (rseq == rx_next);
        if (hit) rx_next = rx_next + 3'd1;
        span = rack - tx_oldest;
        if (span < in_flight) begin
          for (int i = 0; i <= span; i++) begin
            timer_left[tx_oldest] = 16'd0;
            tx_oldest = tx_oldest + 3'd1;
          end
          in_flight = in_flight - span - 3'd1;
        end
        if (hit)
          add_expected(make_word(gbn_pkg::KIND_DELIVERED, rseq, pay, in_flight, 1'b1));
        else
          add_expected(make_word(gbn_pkg::KIND_ACK_ONLY, 3'd0, 64'd0, in_flight, 1'b1));
      end
      gbn_pkg::CMD_TICK: begin
        expired = 1'b0;
        for (int i = 0; i < in_flight; i++) begin
          idx = tx_oldest + 3'(i);
          if (timer_left[idx] != 0) timer_left[idx] = timer_left[idx] - 16'd1;
          if (timer_left[idx] == 0) expired = 1'b1;
        end
        if (expired) begin
          d = retry_deadline();
          for (int i = 0; i < in_flight; i++) begin
            idx = tx_oldest + 3'(i);
            timer_left[idx] = d;
            add_expected(make_word(gbn_pkg::KIND_RESENT, idx, frame_buf[idx], in_flight,
                                   (i + 1 == int'(in_flight))));
          end
        end
      end
      default: ;
    endcase
  endtask

  // Monitor: configuration, input and result words at each rising edge.
  always @(posedge clk) begin
    link_word_t want;
    logic [71:0] want_bits;
    if (!rst_n) begin
      base_ticks <= 16'd3;
      step_ticks <= 8'd3;
      win_limit <= 3'd2;
      tx_next = '0;
      tx_oldest = '0;
      rx_next = '0;
      in_flight = '0;
      for (int i = 0; i < gbn_pkg::SLOTS; i++) begin
        timer_left[i] = '0;
        frame_buf[i] = '0;
      end
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbn_pkg::REG_BASE:  base_ticks <= cfg_wdata;
          gbn_pkg::REG_STEP:  step_ticks <= cfg_wdata[7:0];
          gbn_pkg::REG_LIMIT: win_limit <= cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_link(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected word kind %0d data %h last %b",
                     out_tuser, out_tdata, out_tlast);
          errors <= errors + 1;
        end else begin
          want = expected_words.pop_front();
          want_bits = {2'b00, want.outstanding, want.data, want.seq};
          if (want_bits !== out_tdata || want.kind !== out_tuser ||
              want.last !== out_tlast) begin
            if (errors < 10)
              $display("ERROR: word mismatch, expected kind %0d %h last %b, got kind %0d %h last %b",
                       want.kind, want_bits, want.last, out_tuser, out_tdata, out_tlast);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Go-back-N endpoint testbench
// Drives directed and random sends, arrivals and ticks under several timer
// and window settings with random idles on both channels; the checker does
// the prediction and comparison.
// ---------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 600000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // command
  logic [71:0] in_tdata;   // payload, rx_seq, rx_ack, zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;  // kind
  logic [71:0] out_tdata;  // seq, data, outstanding, zero fill
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic        calm;
  logic        took;
  logic [2:0]  peer_seq;

  go_back_n_link_endpoint_core DUT (.*);

  gbn_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side back-pressure: a fresh stall is drawn after each word.
  always @(posedge clk) took <= out_tvalid && out_tready;
  always @(negedge clk) begin
    int hold;
    if (took) hold = calm ? 0 : $urandom_range(0, 4);
    if (hold > 0) begin
      out_tready <= 1'b0;
      hold = hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic put_word(logic [1:0] cmd, logic [63:0] pay, logic [2:0] rseq,
                          logic [2:0] rack);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, rack, rseq, pay};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (cmd == gbn_pkg::CMD_ARRIVE && rseq == peer_seq) peer_seq = peer_seq + 3'd1;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Let the pipeline drain, including ticks that cause no word.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [15:0] bases[5] = '{16'd3, 16'd1, 16'hFFFF, 16'd2, 16'd6};
    logic [15:0] steps[5] = '{16'd3, 16'd0, 16'd255, 16'd1, 16'd255};
    logic [15:0] limits[5] = '{16'd2, 16'd7, 16'd1, 16'd4, 16'd7};
    int pick;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = gbn_pkg::REG_BASE;
    cfg_wdata = '0;
    calm = 1'b0;
    peer_seq = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme payloads, full window refusal, odd arrivals, ignored word.
    put_word(gbn_pkg::CMD_SEND, 64'd0, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 3'd7);
    put_word(gbn_pkg::CMD_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_TICK, 64'd0, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_TICK, 64'd0, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_TICK, 64'd0, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_ARRIVE, 64'h5555_5555_5555_5555, 3'd7, 3'd5);
    put_word(gbn_pkg::CMD_ARRIVE, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_IGNORED, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 3'd7);
    put_word(gbn_pkg::CMD_ARRIVE, 64'h0123_4567_89AB_CDEF, 3'd1, 3'd1);
    put_word(gbn_pkg::CMD_TICK, 64'd0, 3'd0, 3'd0);
    put_word(gbn_pkg::CMD_SEND, 64'h5555_5555_5555_5555, 3'd0, 3'd0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        write_reg(gbn_pkg::REG_BASE, bases[phase]);
        write_reg(gbn_pkg::REG_STEP, steps[phase]);
        write_reg(gbn_pkg::REG_LIMIT, limits[phase]);
      end
      for (int n = 0; n < 80; n++) begin
        if (n % 40 == 20) calm = 1'b1;
        if (n % 40 == 30) calm = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 35)
          put_word(gbn_pkg::CMD_SEND, rand_payload(), 3'($urandom), 3'($urandom));
        else if (pick < 70)
          put_word(gbn_pkg::CMD_ARRIVE, rand_payload(),
                   ($urandom_range(0, 9) < 7) ? peer_seq : 3'($urandom), 3'($urandom));
        else if (pick < 97)
          put_word(gbn_pkg::CMD_TICK, rand_payload(), 3'($urandom), 3'($urandom));
        else
          put_word(gbn_pkg::CMD_IGNORED, rand_payload(), 3'($urandom), 3'($urandom));
      end
      calm = 1'b0;
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
